// ===== sv/rcpg_pkg.sv =====
// ----------------------------------------------------------------------------
// rcpg_pkg - shared types and constants of the rectangle contour generator
// Sequencer states, segment and divide-operation codes, result status codes
// and the edge register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rcpg_pkg;

    localparam int DATA_W         = 32;          // Q16.16 coordinates
    localparam int DIFF_W         = DATA_W + 1;  // edge difference
    localparam int SUM_W          = DATA_W + 2;  // sum of two differences
    localparam int PNT_IN_W       = 7;           // point_count port width
    localparam int STATUS_W       = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int DEF_MAX_POINTS = 64;
    localparam int MIN_RECT_PNTS  = 4;

    localparam logic [DATA_W-1:0] EDGE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] EDGE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNBOUNDED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_ERR,
        S_MUL,
        S_SHDIV,
        S_DIV,
        S_POST,
        S_NHDIV,
        S_MULK,
        S_SEG,
        S_EMIT
    } t_state;

    // contour segments in emission order, plus the single line segment
    typedef enum logic [2:0] {
        SEG_A,
        SEG_B,
        SEG_C,
        SEG_D,
        SEG_E,
        SEG_F,
        SEG_LINE
    } t_seg;

    typedef enum logic [2:0] {
        OP_SHARE,
        OP_HH,
        OP_HV,
        OP_LV,
        OP_LH
    } t_op;

endpackage

`default_nettype wire

// ===== sv/rectangle_contour_point_generator_top.sv =====
// ----------------------------------------------------------------------------
// rectangle_contour_point_generator_top - contour points of a rectangle
// Takes a point count per request and walks the configured rectangle (or
// line) counterclockwise, giving one Q16.16 point per result.
// ----------------------------------------------------------------------------
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  request   | i_valid / o_stall       | i_point_count
//  result    | o_valid / i_stall       | o_real_part o_imag_part
//            |                         | o_last_point o_status
//  edge cfg  | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
//  One request at a time. A single bit-per-cycle restoring divider does all
//  divisions: the share and each step size. A rectangle is emitted in six
//  segments, a line in one.
//  Reset clears the sequencer and sets every edge to its unbounded value.
//  A stalled result holds the output register; the next request is taken
//  while the last result of the previous one still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_contour_point_generator_top #(
    parameter int MAX_POINTS = rcpg_pkg::DEF_MAX_POINTS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic [rcpg_pkg::PNT_IN_W-1:0]        i_point_count,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [rcpg_pkg::DATA_W-1:0]        o_real_part,
    output logic signed [rcpg_pkg::DATA_W-1:0]        o_imag_part,
    output logic                                      o_last_point,
    output logic [rcpg_pkg::STATUS_W-1:0]             o_status,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [rcpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rcpg_pkg::DATA_W-1:0]          i_cfg_data
);

    localparam int DATA_W   = rcpg_pkg::DATA_W;
    localparam int DIFF_W   = rcpg_pkg::DIFF_W;
    localparam int SUM_W    = rcpg_pkg::SUM_W;
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int PROD_W   = SUM_W + CNT_W + 1;
    localparam int DVD_W    = PROD_W;
    localparam int DSR_W    = SUM_W;
    localparam int SHORT_W  = DIFF_W;
    localparam int IT_W     = $clog2(DVD_W + 1);

    rcpg_pkg::t_state r_state, n_state;
    rcpg_pkg::t_seg   r_seg, n_seg, w_seg_next;
    rcpg_pkg::t_op    r_op, n_op;

    logic [DATA_W-1:0] r_left_edge, r_right_edge, r_bottom_edge, r_top_edge;

    logic [CNT_W-1:0]          r_n, n_n;
    logic [rcpg_pkg::STATUS_W-1:0] r_status, n_status;
    logic signed [PROD_W-1:0]  r_prod, n_prod;
    logic [DVD_W-1:0]          r_quo, n_quo;
    logic [DSR_W-1:0]          r_rem, n_rem;
    logic [DSR_W-1:0]          r_dsr, n_dsr;
    logic                      r_neg, n_neg;
    logic [IT_W-1:0]           r_cnt, n_cnt;
    logic [CNT_W-1:0]          r_nv, n_nv;
    logic [DATA_W-1:0]         r_hh, n_hh, r_hv, n_hv;
    logic [DATA_W-1:0]         r_re, n_re, r_im, n_im, r_dre, n_dre, r_dim, n_dim;
    logic [CNT_W-1:0]          r_pts_left, n_pts_left;
    logic                      r_out_valid, n_out_valid;
    logic [DATA_W-1:0]         r_out_re, n_out_re, r_out_im, n_out_im;
    logic                      r_out_last, n_out_last;
    logic [rcpg_pkg::STATUS_W-1:0] r_out_status, n_out_status;

    logic                      w_accept, w_out_free, w_load, w_last, w_final_seg;
    logic                      w_unb, w_line, w_vline;
    logic signed [DIFF_W-1:0]  w_dv, w_dh, w_sdiv_src;
    logic [SHORT_W-1:0]        w_sdiv_mag;
    logic signed [SUM_W-1:0]   w_den;
    logic [DSR_W-1:0]          w_den_mag;
    logic [PROD_W-1:0]         w_prod_mag;
    logic                      w_share_neg;
    logic signed [SUM_W-1:0]   w_mul_a;
    logic [CNT_W-1:0]          w_mul_b;
    logic signed [PROD_W-1:0]  w_prod;
    logic [DSR_W:0]            w_trial, w_diff;
    logic                      w_ge, w_round_up;
    logic [DVD_W:0]            w_qr;
    logic [CNT_W-1:0]          w_half, w_nmax, w_nv, w_nh, w_k1, w_k0, w_n_sat;
    logic [DATA_W-1:0]         w_qsigned;
    logic [DATA_W-1:0]         w_seg_re, w_seg_im, w_seg_dre, w_seg_dim;
    logic [CNT_W-1:0]          w_seg_cnt;

    // ---------------- edge registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_edge   <= rcpg_pkg::EDGE_MIN;
            r_right_edge  <= rcpg_pkg::EDGE_MAX;
            r_bottom_edge <= rcpg_pkg::EDGE_MIN;
            r_top_edge    <= rcpg_pkg::EDGE_MAX;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rcpg_pkg::REG_LEFT:   r_left_edge   <= i_cfg_data;
                rcpg_pkg::REG_RIGHT:  r_right_edge  <= i_cfg_data;
                rcpg_pkg::REG_BOTTOM: r_bottom_edge <= i_cfg_data;
                rcpg_pkg::REG_TOP:    r_top_edge    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- geometry ----------------
    assign w_dv  = {r_top_edge[DATA_W-1], r_top_edge}
                 - {r_bottom_edge[DATA_W-1], r_bottom_edge};
    assign w_dh  = {r_right_edge[DATA_W-1], r_right_edge}
                 - {r_left_edge[DATA_W-1], r_left_edge};
    assign w_den = {w_dv[DIFF_W-1], w_dv} + {w_dh[DIFF_W-1], w_dh};
    assign w_den_mag = w_den[SUM_W-1] ? -w_den : w_den;

    assign w_unb  = (r_left_edge == rcpg_pkg::EDGE_MIN) || (r_right_edge == rcpg_pkg::EDGE_MAX)
                 || (r_bottom_edge == rcpg_pkg::EDGE_MIN) || (r_top_edge == rcpg_pkg::EDGE_MAX);
    assign w_vline = (r_left_edge == r_right_edge);
    assign w_line  = w_vline || (r_bottom_edge == r_top_edge);

    assign w_n_sat = ({25'd0, i_point_count} > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                                : CNT_W'(i_point_count);

    assign w_half = CNT_W'(r_n >> 1);
    assign w_nmax = w_half - CNT_W'(1);
    assign w_k1   = CNT_W'(r_nv >> 1) + CNT_W'(1);
    assign w_k0   = r_nv - w_k1;
    assign w_nh   = w_half - r_nv;

    // ---------------- shared multiplier ----------------
    assign w_mul_a = (r_state == rcpg_pkg::S_MULK) ? {{(SUM_W-DATA_W){r_hv[DATA_W-1]}}, r_hv}
                                                   : {w_dv[DIFF_W-1], w_dv};
    assign w_mul_b = (r_state == rcpg_pkg::S_MULK) ? w_k1 : w_half;
    assign w_prod  = w_mul_a * $signed({1'b0, w_mul_b});

    // ---------------- shared divider ----------------
    assign w_sdiv_src = (r_state == rcpg_pkg::S_DECIDE) ? (w_vline ? w_dv : w_dh)
                      : (r_state == rcpg_pkg::S_NHDIV)  ? w_dh : w_dv;
    assign w_sdiv_mag = w_sdiv_src[DIFF_W-1] ? -w_sdiv_src : w_sdiv_src;

    assign w_prod_mag  = r_prod[PROD_W-1] ? -r_prod : r_prod;
    assign w_share_neg = (r_prod[PROD_W-1] ^ w_den[SUM_W-1]) && (r_prod != '0);

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});

    assign w_qsigned = r_neg ? -r_quo[DATA_W-1:0] : r_quo[DATA_W-1:0];

    // share rounding: ties go down, then clamp to 1..N/2-1
    assign w_round_up = ({r_rem, 1'b0} > {1'b0, r_dsr});
    assign w_qr       = {1'b0, r_quo} + (DVD_W+1)'(w_round_up);
    always_comb begin
        if (r_neg || (w_qr == '0)) begin
            w_nv = CNT_W'(1);
        end else if (w_qr > (DVD_W+1)'(w_nmax)) begin
            w_nv = w_nmax;
        end else begin
            w_nv = CNT_W'(w_qr);
        end
    end

    // ---------------- segment table ----------------
    always_comb begin
        w_seg_re   = r_left_edge;
        w_seg_im   = r_bottom_edge;
        w_seg_dre  = '0;
        w_seg_dim  = '0;
        w_seg_cnt  = r_n;
        w_seg_next = rcpg_pkg::SEG_LINE;
        case (r_seg)
            rcpg_pkg::SEG_A: begin
                w_seg_re = r_right_edge;
                w_seg_im = r_bottom_edge + r_prod[DATA_W-1:0];
                w_seg_dim = r_hv;
                w_seg_cnt = w_k0;
                w_seg_next = rcpg_pkg::SEG_B;
            end
            rcpg_pkg::SEG_B: begin
                w_seg_re = r_right_edge;
                w_seg_im = r_top_edge;
                w_seg_dre = -r_hh;
                w_seg_cnt = w_nh;
                w_seg_next = rcpg_pkg::SEG_C;
            end
            rcpg_pkg::SEG_C: begin
                w_seg_re = r_left_edge;
                w_seg_im = r_top_edge;
                w_seg_dim = -r_hv;
                w_seg_cnt = w_k1;
                w_seg_next = rcpg_pkg::SEG_D;
            end
            rcpg_pkg::SEG_D: begin
                w_seg_re = r_left_edge;
                w_seg_im = r_top_edge - r_prod[DATA_W-1:0];
                w_seg_dim = -r_hv;
                w_seg_cnt = w_k0;
                w_seg_next = rcpg_pkg::SEG_E;
            end
            rcpg_pkg::SEG_E: begin
                w_seg_re = r_left_edge;
                w_seg_im = r_bottom_edge;
                w_seg_dre = r_hh;
                w_seg_cnt = w_nh;
                w_seg_next = rcpg_pkg::SEG_F;
            end
            rcpg_pkg::SEG_F: begin
                w_seg_re = r_right_edge;
                w_seg_im = r_bottom_edge;
                w_seg_dim = r_hv;
                w_seg_cnt = w_k1;
            end
            default: begin
                w_seg_dre = r_hh;
                w_seg_dim = r_hv;
            end
        endcase
    end

    assign w_final_seg = (r_seg == rcpg_pkg::SEG_F) || (r_seg == rcpg_pkg::SEG_LINE);
    assign w_last      = w_final_seg && (r_pts_left == CNT_W'(1));

    // ---------------- sequencer: next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            rcpg_pkg::S_IDLE: begin
                if (w_accept) n_state = rcpg_pkg::S_DECIDE;
            end
            rcpg_pkg::S_DECIDE: begin
                if (w_unb) begin
                    n_state = rcpg_pkg::S_ERR;
                end else if (w_line) begin
                    if (r_n == '0)                n_state = rcpg_pkg::S_ERR;
                    else if (r_n == CNT_W'(1))    n_state = rcpg_pkg::S_SEG;
                    else                          n_state = rcpg_pkg::S_DIV;
                end else if (r_n < CNT_W'(rcpg_pkg::MIN_RECT_PNTS)) begin
                    n_state = rcpg_pkg::S_ERR;
                end else begin
                    n_state = rcpg_pkg::S_MUL;
                end
            end
            rcpg_pkg::S_ERR: begin
                if (w_load) n_state = rcpg_pkg::S_IDLE;
            end
            rcpg_pkg::S_MUL:   n_state = rcpg_pkg::S_SHDIV;
            rcpg_pkg::S_SHDIV: begin
                n_state = (w_den == '0) ? rcpg_pkg::S_POST : rcpg_pkg::S_DIV;
            end
            rcpg_pkg::S_DIV: begin
                if (r_cnt == IT_W'(1)) n_state = rcpg_pkg::S_POST;
            end
            rcpg_pkg::S_POST: begin
                case (r_op)
                    rcpg_pkg::OP_SHARE: n_state = rcpg_pkg::S_NHDIV;
                    rcpg_pkg::OP_HH:    n_state = rcpg_pkg::S_DIV;
                    rcpg_pkg::OP_HV:    n_state = rcpg_pkg::S_MULK;
                    default:            n_state = rcpg_pkg::S_SEG;
                endcase
            end
            rcpg_pkg::S_NHDIV: n_state = rcpg_pkg::S_DIV;
            rcpg_pkg::S_MULK:  n_state = rcpg_pkg::S_SEG;
            rcpg_pkg::S_SEG: begin
                if (w_seg_cnt != '0) n_state = rcpg_pkg::S_EMIT;
            end
            rcpg_pkg::S_EMIT: begin
                if (w_load && (r_pts_left == CNT_W'(1))) begin
                    n_state = w_final_seg ? rcpg_pkg::S_IDLE : rcpg_pkg::S_SEG;
                end
            end
            default: n_state = rcpg_pkg::S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    always_comb begin
        o_stall     = (r_state != rcpg_pkg::S_IDLE);
        o_cfg_ready = (r_state == rcpg_pkg::S_IDLE);
        w_out_free  = !r_out_valid || !i_stall;
        w_load      = ((r_state == rcpg_pkg::S_EMIT) || (r_state == rcpg_pkg::S_ERR))
                      && w_out_free;
        w_accept    = i_valid && !o_stall;
    end

    // ---------------- datapath ----------------
    always_comb begin
        n_n          = r_n;
        n_status     = r_status;
        n_prod       = r_prod;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_dsr        = r_dsr;
        n_neg        = r_neg;
        n_cnt        = r_cnt;
        n_op         = r_op;
        n_nv         = r_nv;
        n_hh         = r_hh;
        n_hv         = r_hv;
        n_seg        = r_seg;
        n_re         = r_re;
        n_im         = r_im;
        n_dre        = r_dre;
        n_dim        = r_dim;
        n_pts_left   = r_pts_left;
        n_out_valid  = r_out_valid && i_stall;
        n_out_re     = r_out_re;
        n_out_im     = r_out_im;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        case (r_state)
            rcpg_pkg::S_IDLE: begin
                if (w_accept) n_n = w_n_sat;
            end
            rcpg_pkg::S_DECIDE: begin
                n_status = w_unb ? rcpg_pkg::ST_UNBOUNDED : rcpg_pkg::ST_TOO_FEW;
                n_hh     = '0;
                n_hv     = '0;
                n_seg    = rcpg_pkg::SEG_LINE;
                n_quo    = {w_sdiv_mag, {(DVD_W-SHORT_W){1'b0}}};
                n_rem    = '0;
                n_neg    = w_sdiv_src[DIFF_W-1];
                n_dsr    = DSR_W'(r_n - CNT_W'(1));
                n_cnt    = IT_W'(SHORT_W);
                n_op     = w_vline ? rcpg_pkg::OP_LV : rcpg_pkg::OP_LH;
            end
            rcpg_pkg::S_MUL: begin
                n_prod = w_prod;
            end
            rcpg_pkg::S_SHDIV: begin
                n_op  = rcpg_pkg::OP_SHARE;
                n_rem = '0;
                n_cnt = IT_W'(DVD_W);
                if (w_den == '0) begin
                    n_quo = '0;
                    n_neg = 1'b0;
                    n_dsr = '0;
                end else begin
                    n_quo = w_prod_mag;
                    n_neg = w_share_neg;
                    n_dsr = w_den_mag;
                end
            end
            rcpg_pkg::S_DIV: begin
                n_rem = w_ge ? w_diff[DSR_W-1:0] : w_trial[DSR_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], w_ge};
                n_cnt = r_cnt - IT_W'(1);
            end
            rcpg_pkg::S_POST: begin
                case (r_op)
                    rcpg_pkg::OP_SHARE: n_nv = w_nv;
                    rcpg_pkg::OP_HH: begin
                        n_hh  = w_qsigned;
                        n_quo = {w_sdiv_mag, {(DVD_W-SHORT_W){1'b0}}};
                        n_rem = '0;
                        n_neg = w_sdiv_src[DIFF_W-1];
                        n_dsr = DSR_W'(r_nv);
                        n_cnt = IT_W'(SHORT_W);
                        n_op  = rcpg_pkg::OP_HV;
                    end
                    rcpg_pkg::OP_HV: n_hv = w_qsigned;
                    rcpg_pkg::OP_LV: n_hv = w_qsigned;
                    default:         n_hh = w_qsigned;
                endcase
            end
            rcpg_pkg::S_NHDIV: begin
                n_quo = {w_sdiv_mag, {(DVD_W-SHORT_W){1'b0}}};
                n_rem = '0;
                n_neg = w_sdiv_src[DIFF_W-1];
                n_dsr = DSR_W'(w_nh);
                n_cnt = IT_W'(SHORT_W);
                n_op  = rcpg_pkg::OP_HH;
            end
            rcpg_pkg::S_MULK: begin
                n_prod = w_prod;
                n_seg  = rcpg_pkg::SEG_A;
            end
            rcpg_pkg::S_SEG: begin
                if (w_seg_cnt == '0) begin
                    n_seg = w_seg_next;
                end else begin
                    n_re       = w_seg_re;
                    n_im       = w_seg_im;
                    n_dre      = w_seg_dre;
                    n_dim      = w_seg_dim;
                    n_pts_left = w_seg_cnt;
                end
            end
            rcpg_pkg::S_EMIT: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_re     = r_re;
                    n_out_im     = r_im;
                    n_out_last   = w_last;
                    n_out_status = rcpg_pkg::ST_OK;
                    n_re         = r_re + r_dre;
                    n_im         = r_im + r_dim;
                    n_pts_left   = r_pts_left - CNT_W'(1);
                    if (r_pts_left == CNT_W'(1)) n_seg = w_seg_next;
                end
            end
            rcpg_pkg::S_ERR: begin
                if (w_load) begin
                    n_out_valid  = 1'b1;
                    n_out_re     = '0;
                    n_out_im     = '0;
                    n_out_last   = 1'b1;
                    n_out_status = r_status;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcpg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_status     <= n_status;
        r_prod       <= n_prod;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_dsr        <= n_dsr;
        r_neg        <= n_neg;
        r_cnt        <= n_cnt;
        r_op         <= n_op;
        r_nv         <= n_nv;
        r_hh         <= n_hh;
        r_hv         <= n_hv;
        r_seg        <= n_seg;
        r_re         <= n_re;
        r_im         <= n_im;
        r_dre        <= n_dre;
        r_dim        <= n_dim;
        r_pts_left   <= n_pts_left;
        r_out_re     <= n_out_re;
        r_out_im     <= n_out_im;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_valid      = r_out_valid;
    assign o_real_part  = r_out_re;
    assign o_imag_part  = r_out_im;
    assign o_last_point = r_out_last;
    assign o_status     = r_out_status;

    // ---------------- assertions ----------------
    a_last_ends_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcpg_pkg::S_EMIT && w_load && w_last) |=> (r_state == rcpg_pkg::S_IDLE))
        else $error("last point did not end the request");

    a_share_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcpg_pkg::S_NHDIV) |-> (r_nv != '0 && r_nv < w_half))
        else $error("vertical share out of range");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcpg_pkg::S_DIV) |-> (r_dsr != '0))
        else $error("divide by zero in shared divider");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcpg_pkg::S_POST && r_dsr != '0) |-> (r_rem < r_dsr))
        else $error("divider remainder not below divisor");

    a_error_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rcpg_pkg::ST_OK) |-> o_last_point)
        else $error("error result without last marker");

endmodule

`default_nettype wire

// ===== tb/rectangle_contour_point_checker.sv =====
// ----------------------------------------------------------------------------
// rectangle_contour_point_checker - contour point predictor and scoreboard
// Tracks edge register writes, predicts the contour points of every accepted
// request and compares each accepted point, field by field, in order.
// ----------------------------------------------------------------------------
module rectangle_contour_point_checker
    import rcpg_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_req_valid,
    input  wire logic                       i_req_stall,
    input  wire logic [PNT_IN_W-1:0]        i_point_count,
    input  wire logic                       i_pt_valid,
    input  wire logic                       i_pt_stall,
    input  wire logic signed [DATA_W-1:0]   i_real_part,
    input  wire logic signed [DATA_W-1:0]   i_imag_part,
    input  wire logic                       i_last_point,
    input  wire logic [STATUS_W-1:0]        i_status,
    input  wire logic                       i_cfg_valid,
    input  wire logic                       i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [DATA_W-1:0]          i_cfg_data,
    output int                              o_mismatch_count,
    output int                              o_points_pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
        logic                     last;
        logic [STATUS_W-1:0]      status;
    } contour_point_t;

    logic signed [DATA_W-1:0] edge_left   = EDGE_MIN;
    logic signed [DATA_W-1:0] edge_right  = EDGE_MAX;
    logic signed [DATA_W-1:0] edge_bottom = EDGE_MIN;
    logic signed [DATA_W-1:0] edge_top    = EDGE_MAX;

    contour_point_t contour_buf [DEF_MAX_POINTS];
    contour_point_t contour_due [$];
    int             mismatch_count = 0;
    int             report_count   = 0;

    initial begin
        o_mismatch_count = 0;
        o_points_pending = 0;
    end

    function automatic void place(input longint k, input longint re, input longint im);
        contour_buf[k] = '{re[DATA_W-1:0], im[DATA_W-1:0], 1'b0, ST_OK};
    endfunction

    function automatic void predict_contour(input logic [PNT_IN_W-1:0] count_in);
        longint         a, b, c, d, n, dh, dv, hh, hv;
        longint         half, num, den, q, r, nv, nh, k1, k0, i, total;
        contour_point_t p;
        a = edge_left;
        b = edge_right;
        c = edge_bottom;
        d = edge_top;
        n = count_in;
        if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
        dh = b - a;
        dv = d - c;
        hh = 0;
        hv = 0;
        total = 0;
        if (edge_left == EDGE_MIN || edge_right == EDGE_MAX ||
            edge_bottom == EDGE_MIN || edge_top == EDGE_MAX) begin
            contour_due.push_back('{'0, '0, 1'b1, ST_UNBOUNDED});
            return;
        end
        if (a == b || c == d) begin
            if (n == 0) begin
                contour_due.push_back('{'0, '0, 1'b1, ST_TOO_FEW});
                return;
            end
            if (n > 1) begin
                if (a == b) hv = dv / (n - 1);
                else hh = dh / (n - 1);
            end
            for (i = 0; i < n; i++) place(i, a + hh * i, c + hv * i);
            total = n;
        end else begin
            if (n < MIN_RECT_PNTS) begin
                contour_due.push_back('{'0, '0, 1'b1, ST_TOO_FEW});
                return;
            end
            half = n / 2;
            num  = dv * half;
            den  = dv + dh;
            nv   = 0;
            if (den != 0) begin
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                // floor quotient, then round half down
                q = num / den;
                r = num - q * den;
                if (r < 0) begin
                    q--;
                    r += den;
                end
                if (2 * r > den) q++;
                nv = q;
            end
            if (nv < 1) nv = 1;
            if (nv > half - 1) nv = half - 1;
            nh = half - nv;
            hh = dh / nh;
            hv = dv / nv;
            k1 = nv / 2 + 1;
            k0 = nv - k1;
            for (i = k1; i < nv; i++) begin
                place(i - k1, b, c + i * hv);
                place(i - k1 + half, a, d - i * hv);
            end
            for (i = 0; i < nh; i++) begin
                place(i + k0, b - i * hh, d);
                place(i + k0 + half, a + i * hh, c);
            end
            for (i = 0; i < k1; i++) begin
                place(i + k0 + nh, a, d - i * hv);
                place(i + k0 + nh + half, b, c + i * hv);
            end
            total = 2 * half;
        end
        for (i = 0; i < total; i++) begin
            p = contour_buf[i];
            p.last = (i == total - 1);
            contour_due.push_back(p);
        end
    endfunction

    function automatic void flag_field(input string field, input logic [DATA_W-1:0] want,
                                       input logic [DATA_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            // cap the log
            if (report_count < 200) begin
                report_count++;
                $display("%0t: %s mismatch, expected 0x%08h, got 0x%08h",
                         $time, field, want, got);
            end
        end
    endfunction

    function automatic void check_point();
        contour_point_t want;
        if (contour_due.size() == 0) begin
            mismatch_count++;
            if (report_count < 200) begin
                report_count++;
                $display("%0t: point (0x%08h, 0x%08h) with no request outstanding",
                         $time, i_real_part, i_imag_part);
            end
            return;
        end
        want = contour_due.pop_front();
        flag_field("real_part", want.re, i_real_part);
        flag_field("imag_part", want.im, i_imag_part);
        flag_field("last_point", DATA_W'(want.last), DATA_W'(i_last_point));
        flag_field("status", DATA_W'(want.status), DATA_W'(i_status));
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            edge_left   = EDGE_MIN;
            edge_right  = EDGE_MAX;
            edge_bottom = EDGE_MIN;
            edge_top    = EDGE_MAX;
            contour_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LEFT:   edge_left   = i_cfg_data;
                    REG_RIGHT:  edge_right  = i_cfg_data;
                    REG_BOTTOM: edge_bottom = i_cfg_data;
                    REG_TOP:    edge_top    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) predict_contour(i_point_count);
            if (i_pt_valid && !i_pt_stall) check_point();
        end
        o_points_pending <= contour_due.size();
        o_mismatch_count <= mismatch_count;
    end

endmodule

// ===== tb/rectangle_contour_point_generator_top_test.sv =====
// ----------------------------------------------------------------------------
// rectangle_contour_point_generator_top_test - contour generator testbench
// Directed requests over unbounded edges, lines, points, short, odd and
// saturated counts, reversed and zero-sum edges, then random requests over
// many random rectangles and lines, with bursty requests and result stalls.
// ----------------------------------------------------------------------------
module rectangle_contour_point_generator_top_test
    import rcpg_pkg::*;
;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef enum {
        EDGES_SMALL,
        EDGES_FULL,
        EDGES_SKINNY,
        EDGES_LINE_VERT,
        EDGES_LINE_HORIZ,
        EDGES_CORNERS,
        EDGES_UNBOUNDED
    } edge_kind_t;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_valid       = 1'b0;
    logic [PNT_IN_W-1:0]         i_point_count = '0;
    logic                        i_stall       = 1'b0;
    logic                        i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index   = REG_LEFT;
    logic [DATA_W-1:0]           i_cfg_data    = '0;
    logic                        o_stall;
    logic                        o_valid;
    logic signed [DATA_W-1:0]    o_real_part;
    logic signed [DATA_W-1:0]    o_imag_part;
    logic                        o_last_point;
    logic [STATUS_W-1:0]         o_status;
    logic                        o_cfg_ready;

    int          mismatch_total;
    int          points_pending;
    int          burst_left  = 0;
    int          random_sent = 0;
    int          stall_left  = 0;
    stall_mode_t stall_mode  = STALL_NONE;

    rectangle_contour_point_generator_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_count (i_point_count),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_real_part   (o_real_part),
        .o_imag_part   (o_imag_part),
        .o_last_point  (o_last_point),
        .o_status      (o_status),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    rectangle_contour_point_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_stall      (o_stall),
        .i_point_count    (i_point_count),
        .i_pt_valid       (o_valid),
        .i_pt_stall       (i_stall),
        .i_real_part      (o_real_part),
        .i_imag_part      (o_imag_part),
        .i_last_point     (o_last_point),
        .i_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatch_count (mismatch_total),
        .o_points_pending (points_pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #18000000;
        $display("[rectangle_contour_point_generator_top] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(20, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 9) < 6);
            default:     i_stall <= (stall_left[3:0] < 4'd11);
        endcase
    end

    task automatic send_request(input logic [PNT_IN_W-1:0] count);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            gap = $urandom_range(1, 40);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_point_count <= count;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (points_pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_step(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_rect(input logic signed [DATA_W-1:0] lo_re, hi_re, lo_im, hi_im);
        settle();
        cfg_step(REG_LEFT, lo_re);
        cfg_step(REG_RIGHT, hi_re);
        cfg_step(REG_BOTTOM, lo_im);
        cfg_step(REG_TOP, hi_im);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] bounded_word();
        logic signed [DATA_W-1:0] w;
        w = $urandom;
        if (w == EDGE_MIN) w = EDGE_MIN + 1;
        if (w == EDGE_MAX) w = EDGE_MAX - 1;
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] small_word();
        return int'($urandom_range(0, 2097152)) - 1048576;
    endfunction

    function automatic logic signed [DATA_W-1:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return EDGE_MIN + 1;
            1:       return EDGE_MAX - 1;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [PNT_IN_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2) return PNT_IN_W'($urandom_range(0, 3));
        if (r < 4) return PNT_IN_W'($urandom_range(DEF_MAX_POINTS + 1, 127));
        return PNT_IN_W'($urandom_range(MIN_RECT_PNTS, DEF_MAX_POINTS));
    endfunction

    task automatic random_phase();
        logic signed [DATA_W-1:0] e0, e1, e2, e3;
        int                       items;
        edge_kind_t               kind;
        kind = edge_kind_t'($urandom_range(0, 6));
        e0 = small_word();
        e1 = e0 + int'($urandom_range(1, 2097152));
        e2 = small_word();
        e3 = e2 + int'($urandom_range(1, 2097152));
        case (kind)
            EDGES_FULL: begin
                e0 = bounded_word();
                e1 = bounded_word();
                e2 = bounded_word();
                e3 = bounded_word();
            end
            EDGES_SKINNY: begin
                if ($urandom_range(0, 1)) begin
                    e1 = e0 + int'($urandom_range(1, 50));
                    e3 = e2 + int'($urandom_range(4194304, 67108864));
                end else begin
                    e1 = e0 + int'($urandom_range(4194304, 67108864));
                    e3 = e2 + int'($urandom_range(1, 50));
                end
            end
            EDGES_LINE_VERT: begin
                e0 = bounded_word();
                e1 = e0;
                e2 = bounded_word();
                e3 = bounded_word();
            end
            EDGES_LINE_HORIZ: begin
                e0 = bounded_word();
                e1 = bounded_word();
                e2 = bounded_word();
                e3 = e2;
            end
            EDGES_CORNERS: begin
                e0 = corner_word();
                e1 = corner_word();
                e2 = corner_word();
                e3 = corner_word();
            end
            EDGES_UNBOUNDED: begin
                case ($urandom_range(0, 3))
                    0:       e0 = EDGE_MIN;
                    1:       e1 = EDGE_MAX;
                    2:       e2 = EDGE_MIN;
                    default: e3 = EDGE_MAX;
                endcase
            end
            default: ;
        endcase
        set_rect(e0, e1, e2, e3);
        items = $urandom_range(8, 24);
        repeat (items) begin
            send_request(pick_count());
            random_sent++;
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // reset leaves every edge unbounded
        send_request(10);
        send_request(0);
        set_rect(-100000, 200000, -50000, EDGE_MAX);
        send_request(8);
        set_rect(EDGE_MIN, 200000, -50000, 300000);
        send_request(8);
        set_rect(-100000, EDGE_MAX, -50000, 300000);
        send_request(8);
        set_rect(-100000, 200000, EDGE_MIN, 300000);
        send_request(8);

        // plain rectangle: too few, odd and saturated counts
        set_rect(-100000, 200000, -50000, 300000);
        send_request(0);
        send_request(1);
        send_request(2);
        send_request(3);
        send_request(4);
        send_request(5);
        send_request(64);
        send_request(127);

        set_rect(65536, 65536, -131072, 393216);
        send_request(0);
        send_request(1);
        send_request(2);
        send_request(64);
        set_rect(-3, 1000, 7, 7);
        send_request(3);
        send_request(100);
        set_rect(5, 5, 5, 5);
        send_request(5);

        // reversed edges, zero share denominator, negative denominator
        set_rect(300000, -100000, 200000, -50000);
        send_request(8);
        set_rect(0, 100000, 100000, 0);
        send_request(10);
        set_rect(0, 100000, 500000, 0);
        send_request(12);
        set_rect(EDGE_MIN + 1, EDGE_MAX - 1, EDGE_MIN + 1, EDGE_MAX - 1);
        send_request(64);

        while (random_sent < 200) random_phase();

        settle();
        repeat (150) @(posedge i_clk);
        if (mismatch_total == 0 && points_pending == 0) begin
            $display("[rectangle_contour_point_generator_top] OK");
        end else begin
            $display("[rectangle_contour_point_generator_top] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/rcpg_pkg.sv
sv/rectangle_contour_point_generator_top.sv
tb/rectangle_contour_point_checker.sv
tb/rectangle_contour_point_generator_top_test.sv
